// ----- hdl/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants and bit functions of the stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       final_item;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_position;
      logic        last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_INIT,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] START_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] sig0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sig1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// ----- hdl/sha256_stream_if.sv -----
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel that carries one payload beat.
// ----------------------------------------------------------------------------
interface sha256_req_if;
   logic                  valid;
   logic                  ready;
   sha256_pkg::req_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sha256_rsp_if;
   logic                  valid;
   logic                  ready;
   sha256_pkg::rsp_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/sha256_round.sv -----
// ----------------------------------------------------------------------------
// SHA-256 round
// One compression round on the working variables.
// ----------------------------------------------------------------------------
module sha256_round (
   input  logic [31:0] vars_in [8],
   input  logic [31:0] k_word,
   input  logic [31:0] w_word,
   output logic [31:0] vars_out [8]
);
   import sha256_pkg::*;

   logic [31:0] t1;
   logic [31:0] t2;

   always_comb begin
      t1 = vars_in[7] + (rotr(vars_in[4], 6) ^ rotr(vars_in[4], 11) ^ rotr(vars_in[4], 25))
         + ((vars_in[4] & vars_in[5]) ^ (~vars_in[4] & vars_in[6])) + k_word + w_word;
      t2 = (rotr(vars_in[0], 2) ^ rotr(vars_in[0], 13) ^ rotr(vars_in[0], 22))
         + ((vars_in[0] & vars_in[1]) ^ (vars_in[0] & vars_in[2]) ^ (vars_in[1] & vars_in[2]));
      vars_out[0] = t1 + t2;
      vars_out[1] = vars_in[0];
      vars_out[2] = vars_in[1];
      vars_out[3] = vars_in[2];
      vars_out[4] = vars_in[3] + t1;
      vars_out[5] = vars_in[4];
      vars_out[6] = vars_in[5];
      vars_out[7] = vars_in[6];
   end

endmodule

// ----- hdl/sha256_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte stream in, eight digest words out per message.
// ----------------------------------------------------------------------------
// A byte beat that does not complete a block is taken into the block memory.
// The beat that completes a 64-byte block starts a compression, during which
// the input is not ready: the init state loads the 16-word message schedule
// window and the working variables from the block memory and chain value,
// 64 rounds run one per cycle, and the fold state adds the result into the
// chain memory. A final beat pads the block one byte per cycle up to its end
// and compresses it. When more than 55 bytes were held, a second padding
// block and compression follow. The eight digest words leave one per beat,
// and the input stays blocked until the last word is loaded into the output
// register. The chain value lives in an 8-word memory with one read port.
module sha256_stream_hasher (
   input logic         clock,
   input logic         reset,
   sha256_req_if.sink   req,
   sha256_rsp_if.source rsp
);
   import sha256_pkg::*;

   state_type    state_ff, state_in;
   logic [31:0]  block_mem [16];
   logic [31:0]  chain_mem [8];
   logic [31:0]  blk_rd_ff, chain_rd_ff;
   logic [31:0]  acc_ff, acc_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  bits_ff, bits_in;
   logic [63:0]  len_ff, len_in;
   logic         final_ff, final_in;
   logic         pad_ff, pad_in;
   logic         tail_ff, tail_in;
   logic [6:0]   rnd_ff, rnd_in;
   logic [31:0]  vars_ff [8];
   logic [31:0]  vars_in [8];
   logic [31:0]  vars_next [8];
   logic [31:0]  w_win_ff [16];
   logic [31:0]  w_win_in [16];
   logic [3:0]   cnt_ff, cnt_in;
   logic         chain_init_ff, chain_init_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   logic         byte_wr;
   logic [7:0]   byte_val;
   logic [3:0]   blk_wr_addr;
   logic [31:0]  blk_wr_data;
   logic         chain_wr;
   logic [2:0]   chain_wr_addr;
   logic [31:0]  chain_wr_data;
   logic [2:0]   chain_rd_addr;
   logic [3:0]   blk_rd_addr;
   logic [31:0]  w_cur;
   logic [31:0]  chain_now;

   sha256_round u_round (
      .vars_in (vars_ff),
      .k_word  (ROUND_K[rnd_ff[5:0]]),
      .w_word  (w_cur),
      .vars_out(vars_next)
   );

   assign w_cur = (rnd_ff < 7'd16) ? w_win_ff[rnd_ff[3:0]]
                : (w_win_ff[0] + sig0(w_win_ff[1]) + w_win_ff[9] + sig1(w_win_ff[14]));
   assign chain_now = chain_init_ff ? START_HASH[cnt_ff[2:0]] : chain_rd_ff;

   always_ff @(posedge clock) begin
      if (byte_wr) begin
         block_mem[blk_wr_addr] <= blk_wr_data;
      end
      blk_rd_ff <= block_mem[blk_rd_addr];
      if (chain_wr) begin
         chain_mem[chain_wr_addr] <= chain_wr_data;
      end
      chain_rd_ff <= chain_mem[chain_rd_addr];
      acc_ff   <= acc_in;
      len_ff   <= len_in;
      vars_ff  <= vars_in;
      w_win_ff <= w_win_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         bits_ff       <= '0;
         final_ff      <= 1'b0;
         pad_ff        <= 1'b0;
         tail_ff       <= 1'b0;
         rnd_ff        <= '0;
         cnt_ff        <= '0;
         chain_init_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         bits_ff       <= bits_in;
         final_ff      <= final_in;
         pad_ff        <= pad_in;
         tail_ff       <= tail_in;
         rnd_ff        <= rnd_in;
         cnt_ff        <= cnt_in;
         chain_init_ff <= chain_init_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      bits_in       = bits_ff;
      len_in        = len_ff;
      final_in      = final_ff;
      pad_in        = pad_ff;
      tail_in       = tail_ff;
      rnd_in        = rnd_ff;
      cnt_in        = cnt_ff;
      chain_init_in = chain_init_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      acc_in        = acc_ff;
      vars_in       = vars_ff;
      w_win_in      = w_win_ff;
      byte_wr       = 1'b0;
      byte_val      = req.payload.data_byte;
      chain_wr      = 1'b0;
      chain_wr_addr = cnt_ff[2:0];
      chain_wr_data = '0;
      chain_rd_addr = cnt_ff[2:0];
      blk_rd_addr   = cnt_ff;
      req.ready     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               final_in = req.payload.final_item;
               len_in   = bits_ff + {56'd0, req.payload.byte_present, 3'd0};
               if (req.payload.byte_present) begin
                  byte_wr = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  bits_in = len_in;
               end
               cnt_in = '0;
               if (req.payload.byte_present && fill_ff == 6'd63) begin
                  state_in = ST_INIT;
               end else if (req.payload.final_item) begin
                  state_in = ST_PAD;
               end
               if (req.payload.byte_present && fill_ff[1:0] == 2'd0) begin
                  acc_in = {req.payload.data_byte, 24'd0};
               end else if (req.payload.byte_present) begin
                  acc_in = acc_ff | ({24'd0, req.payload.data_byte}
                                     << ((2'd3 - fill_ff[1:0]) * 8));
               end
            end
         end
         ST_PAD: begin
            byte_wr = 1'b1;
            if (tail_ff) begin
               byte_val = len_ff[8'd63 - {fill_ff[2:0], 3'd0} -: 8];
            end else if (!pad_ff) begin
               byte_val = PAD_BYTE;
            end else begin
               byte_val = 8'd0;
            end
            pad_in  = 1'b1;
            fill_in = fill_ff + 6'd1;
            cnt_in  = '0;
            if (!tail_ff && fill_in == LEN_POS) begin
               tail_in = 1'b1;
            end
            if (fill_ff == 6'd63) begin
               state_in = ST_INIT;
            end
            if (fill_ff[1:0] == 2'd0) begin
               acc_in = {byte_val, 24'd0};
            end else begin
               acc_in = acc_ff | ({24'd0, byte_val} << ((2'd3 - fill_ff[1:0]) * 8));
            end
         end
         ST_INIT: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff != 4'd0) begin
               w_win_in[cnt_ff - 4'd1] = blk_rd_ff;
            end
            if (cnt_ff >= 4'd1 && cnt_ff <= 4'd8) begin
               vars_in[cnt_ff[2:0] - 3'd1] = chain_init_ff ? START_HASH[cnt_ff[2:0] - 3'd1]
                                                           : chain_rd_ff;
            end
            if (cnt_ff == 4'd15) begin
               blk_rd_addr = 4'd15;
            end
            if (cnt_ff == 4'd0 && rnd_ff == 7'd0) begin
               rnd_in = 7'd0;
            end
            if (cnt_ff == 4'd15) begin
               rnd_in   = 7'd64;
            end
            if (rnd_ff == 7'd64) begin
               w_win_in[15] = blk_rd_ff;
               rnd_in   = '0;
               cnt_in   = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            vars_in = vars_next;
            rnd_in  = rnd_ff + 7'd1;
            if (rnd_ff >= 7'd16) begin
               for (int i = 0; i < 15; i++) begin
                  w_win_in[i] = w_win_ff[i + 1];
               end
               w_win_in[15] = w_cur;
            end
            if (rnd_ff == 7'd63) begin
               rnd_in   = '0;
               cnt_in   = '0;
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            chain_rd_addr = cnt_ff[2:0] + 3'd1;
            chain_wr      = 1'b1;
            chain_wr_data = chain_now + vars_ff[cnt_ff[2:0]];
            cnt_in        = cnt_ff + 4'd1;
            if (cnt_ff == 4'd7) begin
               chain_init_in = 1'b0;
               cnt_in        = '0;
               chain_rd_addr = 3'd0;
               if (!final_ff) begin
                  state_in = ST_IDLE;
               end else if (tail_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.digest_word  = chain_rd_ff;
               rsp_in.word_position = cnt_ff[2:0];
               rsp_in.last_word    = (cnt_ff == 4'd7);
               chain_rd_addr       = cnt_ff[2:0] + 3'd1;
               cnt_in              = cnt_ff + 4'd1;
               if (cnt_ff == 4'd7) begin
                  chain_init_in = 1'b1;
                  fill_in       = '0;
                  bits_in       = '0;
                  final_in      = 1'b0;
                  pad_in        = 1'b0;
                  tail_in       = 1'b0;
                  cnt_in        = '0;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (rsp_valid_ff && rsp.ready && !(state_ff == ST_EMIT)) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_ROUND && rnd_ff == 7'd63) begin
         chain_rd_addr = 3'd0;
      end
   end

   // Block memory write port: each byte rewrites its word with the bytes gathered so far.
   assign blk_wr_addr = fill_ff[5:2];
   assign blk_wr_data = (fill_ff[1:0] == 2'd0) ? {byte_val, 24'd0}
                      : (acc_ff | ({24'd0, byte_val} << ((2'd3 - fill_ff[1:0]) * 8)));

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   a_emit_order: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && !rsp.payload.last_word |=>
         rsp.valid && rsp.payload.word_position == $past(rsp.payload.word_position) + 3'd1)
      else $error("digest words out of order");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == ST_IDLE)
      else $error("input taken while busy");
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.last_word |-> rsp.payload.word_position == 3'd7)
      else $error("last word flag misplaced");

endmodule
